// ----- hdl/tsl_pkg.sv -----
// ----------------------------------------------------------------------------
// tsl_pkg
// Shared types, codes and helpers for the transfer slot ledger.
// ----------------------------------------------------------------------------
`default_nettype none

package tsl_pkg;

    // Default number of slots and the widest count any configuration can hold.
    localparam int SLOT_COUNT_DEF = 16;
    localparam int COUNT_MAX_W    = 9;

    // Field widths of the transfer channels.
    localparam int OP_W    = 4;
    localparam int INDEX_W = 8;
    localparam int GEN_W   = 32;
    localparam int CODE_W  = 3;
    localparam int STAT_W  = 3;
    localparam int CNT_OUT_W = 5;
    localparam int PHASE_W = 2;

    // Operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_START     = 4'd0,
        OP_SUBMIT    = 4'd1,
        OP_CANCEL    = 4'd2,
        OP_COMPLETE  = 4'd3,
        OP_CANCEL_ALL = 4'd4,
        OP_WATCH_ON  = 4'd5,
        OP_WATCH_OFF = 4'd6,
        OP_RELEASE   = 4'd7,
        OP_READ      = 4'd8
    } op_t;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_BAD_SLOT = 3'd1,
        ST_STALE    = 3'd2,
        ST_ILLEGAL  = 3'd3,
        ST_REFUSED  = 3'd4
    } status_t;

    // Slot phases.
    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE      = 2'd0,
        PH_SUBMITTED = 2'd1,
        PH_CANCEL    = 2'd2,
        PH_DONE      = 2'd3
    } phase_t;

    // Controller states.
    typedef enum logic {
        CTL_IDLE = 1'b0,
        CTL_EXEC = 1'b1
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } tsl_cmd_t;

    // Saturate a slot count to the width of the result fields.
    function automatic logic [CNT_OUT_W-1:0] sat_count(input logic [COUNT_MAX_W-1:0] v);
        logic [CNT_OUT_W-1:0] r;
        if (v > COUNT_MAX_W'(31))
            r = CNT_OUT_W'(31);
        else
            r = v[CNT_OUT_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/tsl_ctrl.sv -----
// ----------------------------------------------------------------------------
// tsl_ctrl
// Sequencer: captures a request, executes it when the result register is
// free, and tracks the valid flag of the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tsl_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output tsl_pkg::tsl_cmd_t     cmd
);

    tsl_pkg::ctl_state_t state_reg, state_next;
    logic                out_valid_reg, out_valid_next;
    logic                result_free;

    // The result register can take a new result when empty or being drained.
    assign result_free = !out_valid_reg || out_ready;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tsl_pkg::CTL_IDLE:
            begin
                if (in_valid)
                    state_next = tsl_pkg::CTL_EXEC;
            end
            tsl_pkg::CTL_EXEC:
            begin
                if (result_free)
                    state_next = tsl_pkg::CTL_IDLE;
            end
            default:
            begin
                state_next = tsl_pkg::CTL_IDLE;
            end
        endcase
    end

    // Output logic: handshake and datapath commands.
    always_comb
    begin
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        case (state_reg)
            tsl_pkg::CTL_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            tsl_pkg::CTL_EXEC:
            begin
                cmd.execute = result_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Result valid flag: set by an execute, cleared when the result is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.execute)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    assign out_valid = out_valid_reg;

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tsl_pkg::CTL_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A captured request is executed in the following cycle or later.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == tsl_pkg::CTL_EXEC))
        else $error("captured request did not reach the execute state");

    // Every execute leaves a valid result behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |=> out_valid_reg)
        else $error("execute did not present a result");

    // A waiting result is never overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd.execute)
        else $error("result overwritten before transfer");

endmodule

`default_nettype wire

// ----- hdl/tsl_datapath.sv -----
// ----------------------------------------------------------------------------
// tsl_datapath
// Slot flops, generation and counters, the operation decode and the result
// register of the transfer slot ledger.
// ----------------------------------------------------------------------------
`default_nettype none

module tsl_datapath #(
    parameter int SLOT_COUNT = tsl_pkg::SLOT_COUNT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tsl_pkg::tsl_cmd_t             cmd,
    input  wire logic [tsl_pkg::OP_W-1:0]      op,
    input  wire logic [tsl_pkg::INDEX_W-1:0]   slot_index,
    input  wire logic [tsl_pkg::GEN_W-1:0]     gen_tag,
    input  wire logic [tsl_pkg::CODE_W-1:0]    completion_code,
    output logic [tsl_pkg::STAT_W-1:0]         status,
    output logic [tsl_pkg::CNT_OUT_W-1:0]      pending_now,
    output logic [tsl_pkg::CNT_OUT_W-1:0]      pending_low,
    output logic [tsl_pkg::CNT_OUT_W-1:0]      finished_now,
    output logic [tsl_pkg::GEN_W-1:0]          gen_now,
    output logic                               observing,
    output logic [tsl_pkg::PHASE_W-1:0]        slot_status,
    output logic [tsl_pkg::CODE_W-1:0]         slot_outcome
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam logic [tsl_pkg::INDEX_W:0] SLOT_LIMIT = (tsl_pkg::INDEX_W + 1)'(SLOT_COUNT);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    // Captured request.
    logic [tsl_pkg::OP_W-1:0]    op_reg;
    logic [tsl_pkg::INDEX_W-1:0] idx_reg;
    logic [tsl_pkg::GEN_W-1:0]   gen_in_reg;
    logic [tsl_pkg::CODE_W-1:0]  code_reg;

    // Ledger state.
    logic [tsl_pkg::PHASE_W-1:0] phase_reg  [SLOT_COUNT];
    logic [tsl_pkg::PHASE_W-1:0] phase_next [SLOT_COUNT];
    logic [tsl_pkg::CODE_W-1:0]  result_reg  [SLOT_COUNT];
    logic [tsl_pkg::CODE_W-1:0]  result_next [SLOT_COUNT];
    logic [tsl_pkg::GEN_W-1:0]   cur_gen_reg, cur_gen_next;
    logic [CNT_W-1:0]            pend_reg, pend_next;
    logic [CNT_W-1:0]            low_reg, low_next;
    logic [CNT_W-1:0]            done_reg, done_next;
    logic                        watch_reg, watch_next;

    // Result register.
    logic [tsl_pkg::STAT_W-1:0]    status_reg;
    logic [tsl_pkg::CNT_OUT_W-1:0] pend_out_reg, low_out_reg, done_out_reg;
    logic [tsl_pkg::GEN_W-1:0]     gen_out_reg;
    logic                          watch_out_reg;
    logic [tsl_pkg::PHASE_W-1:0]   rd_phase_reg;
    logic [tsl_pkg::CODE_W-1:0]    rd_code_reg;

    // Decode helpers.
    logic                        idx_ok;
    logic                        gen_match;
    logic [IDX_W-1:0]            sel;
    logic [tsl_pkg::PHASE_W-1:0] sel_phase;
    logic [tsl_pkg::CODE_W-1:0]  sel_code;
    logic [tsl_pkg::STAT_W-1:0]  status_c;
    logic [tsl_pkg::PHASE_W-1:0] rd_phase_c;
    logic [tsl_pkg::CODE_W-1:0]  rd_code_c;
    logic                        note_low_c;

    assign idx_ok    = {1'b0, idx_reg} < SLOT_LIMIT;
    assign gen_match = gen_in_reg == cur_gen_reg;
    assign sel       = idx_reg[IDX_W-1:0];
    assign sel_phase = idx_ok ? phase_reg[sel] : tsl_pkg::PH_IDLE;
    assign sel_code  = idx_ok ? result_reg[sel] : '0;

    // Capture the request when it is accepted.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= op;
            idx_reg    <= slot_index;
            gen_in_reg <= gen_tag;
            code_reg   <= completion_code;
        end
    end

    // Operation decode and next ledger state.
    always_comb
    begin
        phase_next   = phase_reg;
        result_next  = result_reg;
        cur_gen_next = cur_gen_reg;
        pend_next    = pend_reg;
        low_next     = low_reg;
        done_next    = done_reg;
        watch_next   = watch_reg;
        status_c     = tsl_pkg::ST_OK;
        rd_phase_c   = '0;
        rd_code_c    = '0;
        note_low_c   = 1'b0;
        case (op_reg)
            tsl_pkg::OP_START:
            begin
                if (pend_reg != '0 || gen_in_reg == '0)
                    status_c = tsl_pkg::ST_REFUSED;
                else
                begin
                    for (int i = 0; i < SLOT_COUNT; i++)
                    begin
                        phase_next[i]  = tsl_pkg::PH_IDLE;
                        result_next[i] = '0;
                    end
                    cur_gen_next = gen_in_reg;
                    pend_next    = '0;
                    low_next     = '0;
                    done_next    = '0;
                    watch_next   = 1'b0;
                end
            end
            tsl_pkg::OP_SUBMIT:
            begin
                if (!idx_ok)
                    status_c = tsl_pkg::ST_BAD_SLOT;
                else if (!gen_match)
                    status_c = tsl_pkg::ST_STALE;
                else if (sel_phase != tsl_pkg::PH_IDLE && sel_phase != tsl_pkg::PH_DONE)
                    status_c = tsl_pkg::ST_ILLEGAL;
                else
                begin
                    if (sel_phase == tsl_pkg::PH_DONE && done_reg != '0)
                        done_next = done_reg - CNT_ONE;
                    phase_next[sel] = tsl_pkg::PH_SUBMITTED;
                    pend_next       = pend_reg + CNT_ONE;
                    note_low_c      = 1'b1;
                end
            end
            tsl_pkg::OP_CANCEL:
            begin
                if (!idx_ok)
                    status_c = tsl_pkg::ST_BAD_SLOT;
                else if (!gen_match)
                    status_c = tsl_pkg::ST_STALE;
                else if (sel_phase != tsl_pkg::PH_SUBMITTED)
                    status_c = tsl_pkg::ST_ILLEGAL;
                else
                    phase_next[sel] = tsl_pkg::PH_CANCEL;
            end
            tsl_pkg::OP_COMPLETE:
            begin
                if (!idx_ok)
                    status_c = tsl_pkg::ST_BAD_SLOT;
                else if (!gen_match)
                    status_c = tsl_pkg::ST_STALE;
                else if (sel_phase != tsl_pkg::PH_SUBMITTED && sel_phase != tsl_pkg::PH_CANCEL)
                    status_c = tsl_pkg::ST_ILLEGAL;
                else
                begin
                    phase_next[sel]  = tsl_pkg::PH_DONE;
                    result_next[sel] = code_reg;
                    if (pend_reg != '0)
                        pend_next = pend_reg - CNT_ONE;
                    done_next  = done_reg + CNT_ONE;
                    note_low_c = 1'b1;
                end
            end
            tsl_pkg::OP_CANCEL_ALL:
            begin
                if (!gen_match)
                    status_c = tsl_pkg::ST_STALE;
                else
                begin
                    for (int i = 0; i < SLOT_COUNT; i++)
                    begin
                        if (phase_reg[i] == tsl_pkg::PH_SUBMITTED)
                            phase_next[i] = tsl_pkg::PH_CANCEL;
                    end
                end
            end
            tsl_pkg::OP_WATCH_ON:
            begin
                if (watch_reg || pend_reg == '0)
                    status_c = tsl_pkg::ST_REFUSED;
                else
                begin
                    watch_next = 1'b1;
                    low_next   = pend_reg;
                end
            end
            tsl_pkg::OP_WATCH_OFF:
            begin
                watch_next = 1'b0;
            end
            tsl_pkg::OP_RELEASE:
            begin
                if (pend_reg != '0)
                    status_c = tsl_pkg::ST_REFUSED;
                else
                begin
                    for (int i = 0; i < SLOT_COUNT; i++)
                        phase_next[i] = tsl_pkg::PH_IDLE;
                    done_next = '0;
                end
            end
            tsl_pkg::OP_READ:
            begin
                if (!idx_ok)
                    status_c = tsl_pkg::ST_BAD_SLOT;
                else
                begin
                    rd_phase_c = sel_phase;
                    rd_code_c  = sel_code;
                end
            end
            default:
            begin
                status_c = tsl_pkg::ST_REFUSED;
            end
        endcase

        // Low-water tracking after a submit or a completion.
        if (note_low_c && watch_reg && pend_next < low_reg)
            low_next = pend_next;
    end

    // Slot flops and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                phase_reg[i]  <= tsl_pkg::PH_IDLE;
                result_reg[i] <= '0;
            end
            cur_gen_reg <= '0;
            pend_reg    <= '0;
            low_reg     <= '0;
            done_reg    <= '0;
            watch_reg   <= 1'b0;
        end
        else if (cmd.execute)
        begin
            phase_reg   <= phase_next;
            result_reg  <= result_next;
            cur_gen_reg <= cur_gen_next;
            pend_reg    <= pend_next;
            low_reg     <= low_next;
            done_reg    <= done_next;
            watch_reg   <= watch_next;
        end
    end

    // Result register, loaded with the state after the step.
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            status_reg    <= status_c;
            pend_out_reg  <= tsl_pkg::sat_count(tsl_pkg::COUNT_MAX_W'(pend_next));
            low_out_reg   <= tsl_pkg::sat_count(tsl_pkg::COUNT_MAX_W'(low_next));
            done_out_reg  <= tsl_pkg::sat_count(tsl_pkg::COUNT_MAX_W'(done_next));
            gen_out_reg   <= cur_gen_next;
            watch_out_reg <= watch_next;
            rd_phase_reg  <= rd_phase_c;
            rd_code_reg   <= rd_code_c;
        end
    end

    assign status       = status_reg;
    assign pending_now  = pend_out_reg;
    assign pending_low  = low_out_reg;
    assign finished_now = done_out_reg;
    assign gen_now      = gen_out_reg;
    assign observing    = watch_out_reg;
    assign slot_status  = rd_phase_reg;
    assign slot_outcome = rd_code_reg;

    // Each slot is at most one of pending or finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, pend_reg} + {1'b0, done_reg}) <= (CNT_W + 1)'(SLOT_COUNT))
        else $error("pending and finished counts exceed the slot count");

    // While observing, the low-water mark never exceeds the pending count.
    assert property (@(posedge clk) disable iff (!rst_n)
        watch_reg |-> (low_reg <= pend_reg))
        else $error("low-water mark above pending count");

    // A refused or rejected request leaves the counters untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.execute && status_c != tsl_pkg::ST_OK)
        |=> ($stable(pend_reg) && $stable(done_reg) && $stable(cur_gen_reg)))
        else $error("rejected request changed the ledger counters");

endmodule

`default_nettype wire

// ----- hdl/transfer_slot_ledger_core.sv -----
// ----------------------------------------------------------------------------
// transfer_slot_ledger_core
// Scoreboard for in-flight transfers with generation tagging.
// ----------------------------------------------------------------------------
// Each request is first captured from the input channel and then executed
// against the slot flops and counters, after which one result is presented
// on the output channel. Cancel-all, release and start-generation update
// every slot flop in the same execute cycle, so every operation costs the
// same. A new request can be accepted while the previous result still waits;
// its execute cycle is held until the result register has been emptied, and
// no further request is accepted while one waits to execute.
// ----------------------------------------------------------------------------
`default_nettype none

module transfer_slot_ledger_core #(
    parameter int SLOT_COUNT = tsl_pkg::SLOT_COUNT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [tsl_pkg::OP_W-1:0]      op,
    input  wire logic [tsl_pkg::INDEX_W-1:0]   slot_index,
    input  wire logic [tsl_pkg::GEN_W-1:0]     gen_tag,
    input  wire logic [tsl_pkg::CODE_W-1:0]    completion_code,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [tsl_pkg::STAT_W-1:0]         status,
    output logic [tsl_pkg::CNT_OUT_W-1:0]      pending_now,
    output logic [tsl_pkg::CNT_OUT_W-1:0]      pending_low,
    output logic [tsl_pkg::CNT_OUT_W-1:0]      finished_now,
    output logic [tsl_pkg::GEN_W-1:0]          gen_now,
    output logic                               observing,
    output logic [tsl_pkg::PHASE_W-1:0]        slot_status,
    output logic [tsl_pkg::CODE_W-1:0]         slot_outcome
);

    tsl_pkg::tsl_cmd_t cmd;

    // Sequencer.
    tsl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Ledger datapath.
    tsl_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .op              (op),
        .slot_index      (slot_index),
        .gen_tag         (gen_tag),
        .completion_code (completion_code),
        .status          (status),
        .pending_now     (pending_now),
        .pending_low     (pending_low),
        .finished_now    (finished_now),
        .gen_now         (gen_now),
        .observing       (observing),
        .slot_status     (slot_status),
        .slot_outcome    (slot_outcome)
    );

endmodule

`default_nettype wire
